@@ hw/rtl/calendar_to_millisecond_timestamp_unit_macros.svh @@
// assertion macros shared by the calendar to timestamp rtl
`ifndef CALENDAR_TO_MILLISECOND_TIMESTAMP_UNIT_MACROS_SVH
`define CALENDAR_TO_MILLISECOND_TIMESTAMP_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CTTU_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CTTU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cttu_pkg.sv @@
// package: field widths, tdata layout, calendar constants and month table
`default_nettype none

package cttu_pkg;

    localparam int YIC_W    = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int MS_W     = 10;
    localparam int STAMP_W  = 42;

    localparam int IN_FIELDS_W = YIC_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W + MS_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((STAMP_W + 7) / 8) * 8;

    // input tdata offsets, first field lowest
    localparam int YIC_LSB   = 0;
    localparam int MONTH_LSB = YIC_LSB + YIC_W;
    localparam int DAY_LSB   = MONTH_LSB + MONTH_W;
    localparam int HOUR_LSB  = DAY_LSB + DAY_W;
    localparam int MIN_LSB   = HOUR_LSB + HOUR_W;
    localparam int SEC_LSB   = MIN_LSB + MIN_W;
    localparam int MS_LSB    = SEC_LSB + SEC_W;

    // calendar constants
    localparam int EPOCH_YIC          = 10;
    localparam int CENTURY_YIC        = 100;
    localparam int LEAPS_BEFORE_EPOCH = EPOCH_YIC / 4;
    localparam int DAYS_PER_YEAR      = 365;
    localparam int FEB_MONTH          = 2;
    localparam int LAST_MONTH         = 12;
    localparam int HOURS_PER_DAY      = 24;
    localparam int MINS_PER_HOUR      = 60;
    localparam int SECS_PER_MIN       = 60;
    localparam int MS_PER_SEC         = 1000;

    // accumulator widths, sized for the largest reachable value
    localparam int YDAYS_W = 16;
    localparam int MDAYS_W = 9;
    localparam int LEAP_W  = 5;
    localparam int DAYS_W  = 16;
    localparam int HOURS_W = 21;
    localparam int MINS_W  = 27;
    localparam int SECS_W  = 33;

    typedef enum logic [MONTH_W-1:0] {
        M_NONE = 4'd0,
        M_JAN  = 4'd1,
        M_FEB  = 4'd2,
        M_MAR  = 4'd3,
        M_APR  = 4'd4,
        M_MAY  = 4'd5,
        M_JUN  = 4'd6,
        M_JUL  = 4'd7,
        M_AUG  = 4'd8,
        M_SEP  = 4'd9,
        M_OCT  = 4'd10,
        M_NOV  = 4'd11,
        M_DEC  = 4'd12
    } t_month;

    // addends that ride behind the day count, millis lowest
    typedef struct packed {
        logic              bad;
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
        logic [MS_W-1:0]   millis;
    } t_side;

    localparam int SIDE_W = $bits(t_side);

    // days of the months before this one, common year
    function automatic logic [MDAYS_W-1:0] month_start(input logic [MONTH_W-1:0] mon);
        logic [MDAYS_W-1:0] d;
        d = '0;
        unique case (mon)
            M_JAN:   d = 9'd0;
            M_FEB:   d = 9'd31;
            M_MAR:   d = 9'd59;
            M_APR:   d = 9'd90;
            M_MAY:   d = 9'd120;
            M_JUN:   d = 9'd151;
            M_JUL:   d = 9'd181;
            M_AUG:   d = 9'd212;
            M_SEP:   d = 9'd243;
            M_OCT:   d = 9'd273;
            M_NOV:   d = 9'd304;
            M_DEC:   d = 9'd334;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cttu_front.sv @@
// first stage: unpack the transaction, year days and day-of-year offset
`default_nettype none

module cttu_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [cttu_pkg::IN_TDATA_W-1:0]    i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [cttu_pkg::YDAYS_W-1:0]       o_year_days,
    output logic [cttu_pkg::MDAYS_W-1:0]       o_month_days,
    output cttu_pkg::t_side                    o_side
);
    import cttu_pkg::*;

    `include "calendar_to_millisecond_timestamp_unit_macros.svh"

    logic [YIC_W-1:0]   w_yic;
    logic [MONTH_W-1:0] w_month;
    logic [DAY_W-1:0]   w_day;
    logic [YIC_W-1:0]   w_yic_m1;
    logic [YIC_W-1:0]   w_years;
    logic [LEAP_W-1:0]  w_leaps;
    logic               w_after_epoch;
    logic               w_leap_now;
    logic               w_bad;

    logic [YDAYS_W-1:0] n_year_days;
    logic [MDAYS_W-1:0] n_month_days;
    t_side              n_side;

    logic               r_valid;
    logic [YDAYS_W-1:0] r_year_days;
    logic [MDAYS_W-1:0] r_month_days;
    t_side              r_side;

    assign w_yic   = i_data[YIC_LSB +: YIC_W];
    assign w_month = i_data[MONTH_LSB +: MONTH_W];
    assign w_day   = i_data[DAY_LSB +: DAY_W];

    always_comb begin
        w_bad         = (w_month == M_NONE) || (w_month > MONTH_W'(LAST_MONTH));
        w_after_epoch = w_yic > YIC_W'(EPOCH_YIC);
        w_yic_m1      = w_yic - YIC_W'(1);
        w_years       = w_after_epoch ? (w_yic - YIC_W'(EPOCH_YIC)) : '0;
        // leap years from the epoch up to last year; the century year is common
        w_leaps       = w_after_epoch
                      ? (LEAP_W'(w_yic_m1[YIC_W-1:2]) - LEAP_W'(LEAPS_BEFORE_EPOCH)
                         - LEAP_W'(w_yic > YIC_W'(CENTURY_YIC)))
                      : '0;
        w_leap_now    = (w_yic[1:0] == 2'b00) && (w_yic != YIC_W'(CENTURY_YIC));

        n_year_days   = YDAYS_W'(w_years) * YDAYS_W'(DAYS_PER_YEAR) + YDAYS_W'(w_leaps);
        n_month_days  = month_start(w_month)
                      + MDAYS_W'(w_leap_now && (w_month > MONTH_W'(FEB_MONTH)))
                      + MDAYS_W'(w_day);

        n_side.bad     = w_bad;
        n_side.hours   = i_data[HOUR_LSB +: HOUR_W];
        n_side.minutes = i_data[MIN_LSB +: MIN_W];
        n_side.seconds = i_data[SEC_LSB +: SEC_W];
        n_side.millis  = i_data[MS_LSB +: MS_W];

        // an invalid month flushes every addend so the chain yields zero
        if (w_bad) begin
            n_year_days    = '0;
            n_month_days   = '0;
            n_side.hours   = '0;
            n_side.minutes = '0;
            n_side.seconds = '0;
            n_side.millis  = '0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_year_days  <= n_year_days;
            r_month_days <= n_month_days;
            r_side       <= n_side;
        end
    end

    assign o_valid      = r_valid;
    assign o_year_days  = r_year_days;
    assign o_month_days = r_month_days;
    assign o_side       = r_side;

    `CTTU_ASSERT_IMPL(a_bad_flushes, r_valid && r_side.bad,
        r_year_days == '0 && r_month_days == '0 && r_side.hours == '0
        && r_side.minutes == '0 && r_side.seconds == '0 && r_side.millis == '0,
        "bad month left a non-zero addend")

endmodule

`default_nettype wire

@@ hw/rtl/cttu_mul_add.sv @@
// one pipeline stage: acc * factor + addend, with pass-along side bits
`default_nettype none

module cttu_mul_add #(
    parameter int IN_W   = 16,
    parameter int ADD_W  = 9,
    parameter int SIDE_W = 1,
    parameter int OUT_W  = 21,
    parameter int FACTOR = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [IN_W-1:0]   i_acc,
    input  logic [ADD_W-1:0]  i_add,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_W-1:0]  o_acc,
    output logic [SIDE_W-1:0] o_side
);
    `include "calendar_to_millisecond_timestamp_unit_macros.svh"

    logic [OUT_W-1:0]  n_acc;
    logic              r_valid;
    logic [OUT_W-1:0]  r_acc;
    logic [SIDE_W-1:0] r_side;

    // constant factor, synthesis folds it into shifts and adds
    assign n_acc   = OUT_W'(i_acc) * OUT_W'(FACTOR) + OUT_W'(i_add);
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_acc  <= n_acc;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_side  = r_side;

    `CTTU_ASSERT_NEXT(a_take_lands, i_valid && o_ready, o_valid,
        "accepted transaction did not reach the stage register")

endmodule

`default_nettype wire

@@ hw/rtl/calendar_to_millisecond_timestamp_unit.sv @@
// throughput: one transaction per cycle while i_m_tready is high, stages advance independently on back-pressure
// stages: calendar lookup, day sum, then x24, x60, x60 and x1000 multiply-add steps
// reset: synchronous active-low, clears the stage valid bits only
`default_nettype none

module calendar_to_millisecond_timestamp_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // year_in_century, month, day_of_month, hours, minutes, seconds, milliseconds
    input  logic [cttu_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // stamp_ms
    output logic [cttu_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // bad_month
    output logic                              o_m_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready
);
    import cttu_pkg::*;

    `include "calendar_to_millisecond_timestamp_unit_macros.svh"

    localparam int S2_SIDE_W = 1 + MIN_W + SEC_W + MS_W;
    localparam int S3_SIDE_W = 1 + SEC_W + MS_W;
    localparam int S4_SIDE_W = 1 + MS_W;
    localparam int S5_SIDE_W = 1;

    logic               w_f_valid, w_f_ready;
    logic [YDAYS_W-1:0] w_f_year_days;
    logic [MDAYS_W-1:0] w_f_month_days;
    t_side              w_f_side;

    logic               w_d_valid, w_d_ready;
    logic [DAYS_W-1:0]  w_d_acc;
    t_side              w_d_side;

    logic                 w_h_valid, w_h_ready;
    logic [HOURS_W-1:0]   w_h_acc;
    logic [S2_SIDE_W-1:0] w_h_side;

    logic                 w_n_valid, w_n_ready;
    logic [MINS_W-1:0]    w_n_acc;
    logic [S3_SIDE_W-1:0] w_n_side;

    logic                 w_c_valid, w_c_ready;
    logic [SECS_W-1:0]    w_c_acc;
    logic [S4_SIDE_W-1:0] w_c_side;

    logic [STAMP_W-1:0]   w_stamp;
    logic [S5_SIDE_W-1:0] w_m_side;

    cttu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_data       (i_s_tdata),
        .o_valid      (w_f_valid),
        .i_ready      (w_f_ready),
        .o_year_days  (w_f_year_days),
        .o_month_days (w_f_month_days),
        .o_side       (w_f_side)
    );

    // total days: year days plus day of year
    cttu_mul_add #(
        .IN_W (YDAYS_W), .ADD_W (MDAYS_W), .SIDE_W (SIDE_W), .OUT_W (DAYS_W), .FACTOR (1)
    ) u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_acc   (w_f_year_days),
        .i_add   (w_f_month_days),
        .i_side  (w_f_side),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_acc   (w_d_acc),
        .o_side  (w_d_side)
    );

    cttu_mul_add #(
        .IN_W (DAYS_W), .ADD_W (HOUR_W), .SIDE_W (S2_SIDE_W), .OUT_W (HOURS_W),
        .FACTOR (HOURS_PER_DAY)
    ) u_hours (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_acc   (w_d_acc),
        .i_add   (w_d_side.hours),
        .i_side  ({w_d_side.bad, w_d_side.minutes, w_d_side.seconds, w_d_side.millis}),
        .o_valid (w_h_valid),
        .i_ready (w_h_ready),
        .o_acc   (w_h_acc),
        .o_side  (w_h_side)
    );

    cttu_mul_add #(
        .IN_W (HOURS_W), .ADD_W (MIN_W), .SIDE_W (S3_SIDE_W), .OUT_W (MINS_W),
        .FACTOR (MINS_PER_HOUR)
    ) u_mins (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_h_valid),
        .o_ready (w_h_ready),
        .i_acc   (w_h_acc),
        .i_add   (w_h_side[SEC_W+MS_W +: MIN_W]),
        .i_side  ({w_h_side[S2_SIDE_W-1], w_h_side[SEC_W+MS_W-1:0]}),
        .o_valid (w_n_valid),
        .i_ready (w_n_ready),
        .o_acc   (w_n_acc),
        .o_side  (w_n_side)
    );

    cttu_mul_add #(
        .IN_W (MINS_W), .ADD_W (SEC_W), .SIDE_W (S4_SIDE_W), .OUT_W (SECS_W),
        .FACTOR (SECS_PER_MIN)
    ) u_secs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_n_valid),
        .o_ready (w_n_ready),
        .i_acc   (w_n_acc),
        .i_add   (w_n_side[MS_W +: SEC_W]),
        .i_side  ({w_n_side[S3_SIDE_W-1], w_n_side[MS_W-1:0]}),
        .o_valid (w_c_valid),
        .i_ready (w_c_ready),
        .o_acc   (w_c_acc),
        .o_side  (w_c_side)
    );

    // last stage register doubles as the output register
    cttu_mul_add #(
        .IN_W (SECS_W), .ADD_W (MS_W), .SIDE_W (S5_SIDE_W), .OUT_W (STAMP_W),
        .FACTOR (MS_PER_SEC)
    ) u_millis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid),
        .o_ready (w_c_ready),
        .i_acc   (w_c_acc),
        .i_add   (w_c_side[MS_W-1:0]),
        .i_side  (w_c_side[S4_SIDE_W-1 -: S5_SIDE_W]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_acc   (w_stamp),
        .o_side  (w_m_side)
    );

    assign o_m_tdata = OUT_TDATA_W'(w_stamp);
    assign o_m_tuser = w_m_side[0];

    `CTTU_ASSERT_IMPL(a_bad_gives_zero, o_m_tvalid && o_m_tuser, o_m_tdata == '0,
        "bad month produced a non-zero stamp")
    `CTTU_ASSERT_IMPL(a_free_output_frees_input, !o_m_tvalid || i_m_tready, o_s_tready,
        "input stalled although the output side can drain")

endmodule

`default_nettype wire

@@ tb/calendar_to_millisecond_timestamp_unit_tb.sv @@
// testbench for the calendar to millisecond timestamp unit
`default_nettype none

module calendar_to_millisecond_timestamp_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cttu_pkg::*;

    localparam int PIPE_LAT       = 6;
    localparam int RANDOM_PER_SET = 275;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int FULL_YEAR_BASE = 2000;
    localparam int EPOCH_YEAR     = 2010;

    typedef struct {
        logic [YIC_W-1:0]   yic;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hours;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic [MS_W-1:0]    millis;
    } t_cal_time;

    typedef struct {
        logic [STAMP_W-1:0] stamp;
        logic               bad;
    } t_stamp_result;

    typedef struct {
        t_cal_time     t;
        bit            typed;
        t_stamp_result want;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   i_m_tready = 1'b0;
    wire                    o_s_tready;
    wire [OUT_TDATA_W-1:0]  o_m_tdata;
    wire                    o_m_tuser;
    wire                    o_m_tvalid;

    t_stamp_result pending_stamps[$];
    t_dir_row      dir_table[$];
    int            mismatches = 0;
    int            cycles = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;

    calendar_to_millisecond_timestamp_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned yr);
        return ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
    endfunction

    function automatic t_stamp_result calendar_to_stamp(input t_cal_time t);
        t_stamp_result     r;
        longint unsigned   days;
        int unsigned       full_year;
        int unsigned       month_days [12];
        month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        r.stamp = '0;
        r.bad = 1'b0;
        if (t.month < M_JAN || t.month > M_DEC) begin
            r.bad = 1'b1;
            return r;
        end
        full_year = FULL_YEAR_BASE + t.yic;
        days = 0;
        // years before the epoch contribute nothing
        for (int unsigned yr = EPOCH_YEAR; yr < full_year; yr++)
            days += 64'(leap_year(yr) ? 366 : 365);
        for (int unsigned k = M_JAN; k < t.month; k++) begin
            if (k == M_FEB)
                days += 64'(leap_year(full_year) ? 29 : 28);
            else
                days += 64'(month_days[k-1]);
        end
        days += 64'(t.day);
        days = days * 64'd24 + 64'(t.hours);
        days = days * 64'd60 + 64'(t.minutes);
        days = days * 64'd60 + 64'(t.seconds);
        days = days * 64'd1000 + 64'(t.millis);
        r.stamp = days[STAMP_W-1:0];
        return r;
    endfunction

    function automatic t_dir_row row(input int unsigned y, input int unsigned mo,
                                     input int unsigned d, input int unsigned h,
                                     input int unsigned mi, input int unsigned s,
                                     input int unsigned ms, input bit typed,
                                     input longint unsigned stamp, input bit bad);
        t_dir_row r;
        r.t.yic = YIC_W'(y);
        r.t.month = MONTH_W'(mo);
        r.t.day = DAY_W'(d);
        r.t.hours = HOUR_W'(h);
        r.t.minutes = MIN_W'(mi);
        r.t.seconds = SEC_W'(s);
        r.t.millis = MS_W'(ms);
        r.typed = typed;
        r.want.stamp = STAMP_W'(stamp);
        r.want.bad = bad;
        return r;
    endfunction

    // mostly calendar-sane values, the rest across the full field widths
    function automatic t_cal_time random_time();
        t_cal_time t;
        if ($urandom_range(99) < 75) begin
            t.yic = YIC_W'($urandom_range(99));
            t.month = MONTH_W'($urandom_range(M_DEC, M_JAN));
            t.day = DAY_W'($urandom_range(31, 1));
            t.hours = HOUR_W'($urandom_range(23));
            t.minutes = MIN_W'($urandom_range(59));
            t.seconds = SEC_W'($urandom_range(59));
            t.millis = MS_W'($urandom_range(999));
        end else begin
            t.yic = YIC_W'($urandom);
            t.month = MONTH_W'($urandom);
            t.day = DAY_W'($urandom);
            t.hours = HOUR_W'($urandom);
            t.minutes = MIN_W'($urandom);
            t.seconds = SEC_W'($urandom);
            t.millis = MS_W'($urandom);
        end
        return t;
    endfunction

    // call it just after the rising clock; leaves tvalid high after the transaction
    task automatic send_time(input t_cal_time t, input t_stamp_result want);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[YIC_LSB   +: YIC_W]   = t.yic;
        word[MONTH_LSB +: MONTH_W] = t.month;
        word[DAY_LSB   +: DAY_W]   = t.day;
        word[HOUR_LSB  +: HOUR_W]  = t.hours;
        word[MIN_LSB   +: MIN_W]   = t.minutes;
        word[SEC_LSB   +: SEC_W]   = t.seconds;
        word[MS_LSB    +: MS_W]    = t.millis;
        if ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= word;
        do @(posedge i_clk); while (!o_s_tready);
        pending_stamps.push_back(want);
    endtask

    task automatic drain_stamps();
        do @(posedge i_clk); while (pending_stamps.size() != 0);
    endtask

    // receiver: random stall and result check on the pre-edge values
    always @(posedge i_clk) begin
        t_stamp_result want;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_stamps.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result stamp %h bad %b", $time,
                         o_m_tdata[STAMP_W-1:0], o_m_tuser);
            end else begin
                want = pending_stamps.pop_front();
                if (o_m_tdata[STAMP_W-1:0] !== want.stamp) begin
                    mismatches++;
                    $display("%0t: stamp expected %0d actual %0d", $time,
                             want.stamp, o_m_tdata[STAMP_W-1:0]);
                end
                if (o_m_tuser !== want.bad) begin
                    mismatches++;
                    $display("%0t: bad_month expected %b actual %b", $time,
                             want.bad, o_m_tuser);
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_stamp_result want;
        t_cal_time     t;
        // epoch, 999 milliseconds, one day
        dir_table.push_back(row(10, M_JAN, 0, 0, 0, 0, 0, 1, 0, 0));
        dir_table.push_back(row(10, M_JAN, 0, 0, 0, 0, 999, 1, 999, 0));
        dir_table.push_back(row(10, M_JAN, 1, 0, 0, 0, 0, 1, 86400000, 0));
        // month out of range gives a zero stamp and the flag
        dir_table.push_back(row(0, M_NONE, 0, 0, 0, 0, 0, 1, 0, 1));
        dir_table.push_back(row(127, 13, 31, 31, 63, 63, 1023, 1, 0, 1));
        dir_table.push_back(row(55, 14, 15, 12, 30, 30, 500, 1, 0, 1));
        dir_table.push_back(row(99, 15, 31, 23, 59, 59, 999, 1, 0, 1));
        // every field at its top, with the month at december
        dir_table.push_back(row(127, M_DEC, 31, 31, 63, 63, 1023, 0, 0, 0));
        // years before the epoch, 2000 being a leap year
        dir_table.push_back(row(0, M_JAN, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(0, M_MAR, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(9, M_DEC, 31, 23, 59, 59, 999, 0, 0, 0));
        // february around leap and common years
        dir_table.push_back(row(11, M_MAR, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(12, M_FEB, 29, 12, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(12, M_MAR, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(99, M_DEC, 31, 23, 59, 59, 999, 0, 0, 0));
        // beyond the century: 2100 is common, 2104 leap
        dir_table.push_back(row(100, M_MAR, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(104, M_MAR, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(127, M_JUN, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(16, M_APR, 30, 12, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(20, M_MAY, 31, 6, 15, 45, 250, 0, 0, 0));
        dir_table.push_back(row(30, M_JUL, 4, 18, 30, 0, 1, 0, 0, 0));
        dir_table.push_back(row(45, M_AUG, 15, 1, 2, 3, 4, 0, 0, 0));
        dir_table.push_back(row(60, M_SEP, 9, 9, 9, 9, 9, 0, 0, 0));
        dir_table.push_back(row(75, M_OCT, 31, 20, 40, 20, 800, 0, 0, 0));
        dir_table.push_back(row(88, M_NOV, 30, 23, 59, 59, 999, 0, 0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i]) begin
            want = dir_table[i].typed ? dir_table[i].want : calendar_to_stamp(dir_table[i].t);
            send_time(dir_table[i].t, want);
        end

        for (int set = 0; set < 4; set++) begin
            case (set)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (int n = 0; n < RANDOM_PER_SET; n++) begin
                // sender holds off until the pipeline has emptied
                if (set == 2 && n == RANDOM_PER_SET / 2) begin
                    i_s_tvalid <= 1'b0;
                    drain_stamps();
                end
                t = random_time();
                send_time(t, calendar_to_stamp(t));
            end
        end

        i_s_tvalid <= 1'b0;
        drain_stamps();
        repeat (4 * PIPE_LAT) @(posedge i_clk);
        if (mismatches == 0 && pending_stamps.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/cttu_pkg.sv
hw/rtl/cttu_front.sv
hw/rtl/cttu_mul_add.sv
hw/rtl/calendar_to_millisecond_timestamp_unit.sv
tb/calendar_to_millisecond_timestamp_unit_tb.sv
